// File: hdl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam int STAMP_W = 32;
	localparam int COUNT_W = 32;
	localparam int POS_W   = 48;
	localparam int ANG_W   = 32;
	localparam int SPD_W   = 32;

	localparam int DVD_W = 106;

	localparam logic [31:0] CORDIC_GAIN_Q32 = 32'h9B74_EDA8;
	localparam logic [31:0] PI_Q29          = 32'd1686629713;
	localparam logic [31:0] MS_PER_S        = 32'd1000;

	localparam logic [31:0] RST_LEFT_DPT  = 32'd407199;
	localparam logic [31:0] RST_RIGHT_DPT = 32'd407199;
	localparam logic [31:0] RST_TURN_GAIN = 32'd1708913188;

	localparam logic [1:0] REG_LEFT_DPT  = 2'd0;
	localparam logic [1:0] REG_RIGHT_DPT = 2'd1;
	localparam logic [1:0] REG_TURN_GAIN = 2'd2;

	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			5'd31: v = 32'h00000000;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Saturate a magnitude with a separate sign to a 32-bit two's complement value.
	function automatic logic [31:0] sat32(input logic [DVD_W-1:0] mag, input logic neg);
		logic [31:0] lim;
		logic [31:0] m;
		lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		m = (mag > DVD_W'(lim)) ? lim : mag[31:0];
		return neg ? (32'd0 - m) : m;
	endfunction

endpackage
`default_nettype wire

// File: hdl/ddo_if.sv
`default_nettype none
interface ddo_in_if;
	import ddo_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [STAMP_W-1:0]        stamp_ms;
	logic signed [COUNT_W-1:0] count_left;
	logic signed [COUNT_W-1:0] count_right;
	modport source(output valid, stamp_ms, count_left, count_right, input ready);
	modport sink(input valid, stamp_ms, count_left, count_right, output ready);
endinterface

interface ddo_out_if;
	import ddo_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [ANG_W-1:0] heading_angle;
	logic signed [SPD_W-1:0] lin_speed;
	logic signed [SPD_W-1:0] ang_speed;
	logic                    speed_valid;
	modport source(output valid, pos_x, pos_y, heading_angle, lin_speed, ang_speed,
		speed_valid, input ready);
	modport sink(input valid, pos_x, pos_y, heading_angle, lin_speed, ang_speed,
		speed_valid, output ready);
endinterface
`default_nettype wire

// File: hdl/differential_drive_odometry_unit.sv
// Differential-drive wheel odometry.
// The input channel carries a millisecond timestamp and the two absolute encoder
// counts; the output channel returns one pose and speed result per input transfer.
// Calibration (travel per tick for each wheel, turn gain) is written over the APB
// port at byte addresses 0, 4 and 8; reads return the values. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The first item after reset only latches counts and timestamp and returns the
// current pose with zero speeds through the final state into the output register.
// For every later item one shared 32x32 multiplier runs up to seven wide products
// limb by limb, one CORDIC rotation step runs per cycle, and two 106-step restoring
// divisions by the time delta form the speeds. A zero time delta skips the speed work.
// The next item is taken once the sequencer is back in idle; a finished result waits
// in the output register while the receiver stalls and the block already accepts the
// next item. A second result is held back until the receiver takes the first.
// Reset restores the default calibration, clears the pose and the output valid.
`default_nettype none
module differential_drive_odometry_unit #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ddo_in_if.sink           in_ch,
	ddo_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ddo_pkg::*;

	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int CW = $clog2(DVD_W);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_POST = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_ABS  = 4'd5;
	localparam logic [3:0] S_CORD = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	localparam logic [2:0] OP_L   = 3'd0;
	localparam logic [2:0] OP_R   = 3'd1;
	localparam logic [2:0] OP_T   = 3'd2;
	localparam logic [2:0] OP_X   = 3'd3;
	localparam logic [2:0] OP_V1  = 3'd4;
	localparam logic [2:0] OP_V2A = 3'd5;
	localparam logic [2:0] OP_V2B = 3'd6;

	logic [3:0]  state_q;
	logic [31:0] lpt_q, rpt_q, gain_q;
	logic [31:0] prev_left_q, prev_right_q, prev_stamp_q;
	logic        primed_q;
	logic [POS_W-1:0] acc_x_q, acc_y_q;
	logic [31:0] acc_h_q;

	logic [31:0] stamp_q, cl_q, cr_q;
	logic [31:0] dt_q, magl_q, magr_q;
	logic        negl_q, negr_q;
	logic signed [56:0] dl_q, dr_q;
	logic signed [57:0] sum_q, diff_q;
	logic [55:0] dsm_q;
	logic        dsneg_q;
	logic        tneg_q;
	logic [63:0] tmag_q, tlow_q;

	logic [2:0]   mop_q;
	logic [1:0]   limb_q;
	logic [95:0]  ma_q;
	logic [31:0]  mb_q;
	logic [63:0]  prod_q;
	logic [127:0] macc_q;

	logic signed [63:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [SW-1:0]      step_q;

	logic [DVD_W-1:0] dvd_q;
	logic [32:0]      rem_q;
	logic [CW-1:0]    dcnt_q;
	logic             dop_q;

	logic [31:0] lin_q, ang_q;
	logic        valid_q;

	logic             ovalid_q;
	logic [POS_W-1:0] ox_q, oy_q;
	logic [31:0]      oh_q, olin_q, oang_q;
	logic             ospd_q;

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_LEFT_DPT:  prdata = lpt_q;
			REG_RIGHT_DPT: prdata = rpt_q;
			REG_TURN_GAIN: prdata = gain_q;
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpt_q  <= RST_LEFT_DPT;
			rpt_q  <= RST_RIGHT_DPT;
			gain_q <= RST_TURN_GAIN;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LEFT_DPT:  lpt_q  <= pwdata;
				REG_RIGHT_DPT: rpt_q  <= pwdata;
				REG_TURN_GAIN: gain_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Combinational helpers
	logic        in_xfer, out_xfer, slot_free;
	logic [31:0] dtl, dtr, limb;
	logic [63:0] prod_d;
	logic [127:0] macc_add;
	logic [54:0] whm;
	logic signed [56:0] whd;
	logic signed [57:0] ds_full;
	logic [63:0] tmag_d;
	logic [55:0] xm;
	logic signed [63:0] x_init;
	logic [31:0] phi, phi_f;
	logic        fold;
	logic signed [63:0] xs, ys;
	logic signed [33:0] atz;
	logic [32:0] rsh;
	logic        qbit;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = ovalid_q && out_ch.ready;
	assign slot_free   = !ovalid_q || out_ch.ready;

	assign dtl = cl_q - prev_left_q;
	assign dtr = cr_q - prev_right_q;

	always_comb begin
		unique case (limb_q)
			2'd0:    limb = ma_q[31:0];
			2'd1:    limb = ma_q[63:32];
			default: limb = ma_q[95:64];
		endcase
	end
	assign prod_d = 64'(limb) * 64'(mb_q);

	always_comb begin
		unique case (limb_q)
			2'd1:    macc_add = {64'd0, prod_q};
			2'd2:    macc_add = {32'd0, prod_q, 32'd0};
			2'd3:    macc_add = {prod_q, 64'd0};
			default: macc_add = 128'd0;
		endcase
	end

	// Wheel distance from the finished product, 2^-24 m.
	always_comb begin
		whm = macc_q[62:8];
		if ((mop_q == OP_L) ? negl_q : negr_q)
			whd = -$signed({2'b00, whm});
		else
			whd = $signed({2'b00, whm});
	end

	assign ds_full = $signed(sum_q + 58'(sum_q[57])) >>> 1;
	assign tmag_d  = macc_q[87:24];

	assign xm     = macc_q[87:32];
	assign x_init = dsneg_q ? -$signed({8'd0, xm}) : $signed({8'd0, xm});
	assign phi    = acc_h_q + tlow_q[32:1];
	// Back quadrants are folded by negating the vector and adding pi.
	assign fold   = phi[31] ^ phi[30];
	assign phi_f  = {phi[31] ^ fold, phi[30:0]};

	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign atz = $signed({2'b00, atan_lut(5'(step_q))});

	assign rsh  = {rem_q[31:0], dvd_q[DVD_W-1]};
	assign qbit = (rsh >= {1'b0, dt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			primed_q     <= 1'b0;
			prev_left_q  <= 32'd0;
			prev_right_q <= 32'd0;
			prev_stamp_q <= 32'd0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_h_q      <= 32'd0;
			ovalid_q     <= 1'b0;
			mop_q        <= OP_L;
			limb_q       <= 2'd0;
			step_q       <= '0;
			dcnt_q       <= '0;
			dop_q        <= 1'b0;
		end else begin
			if (out_xfer)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						stamp_q <= in_ch.stamp_ms;
						cl_q    <= in_ch.count_left;
						cr_q    <= in_ch.count_right;
						if (!primed_q) begin
							primed_q     <= 1'b1;
							prev_left_q  <= in_ch.count_left;
							prev_right_q <= in_ch.count_right;
							prev_stamp_q <= in_ch.stamp_ms;
							lin_q        <= 32'd0;
							ang_q        <= 32'd0;
							valid_q      <= 1'b0;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					dt_q         <= stamp_q - prev_stamp_q;
					negl_q       <= dtl[31];
					negr_q       <= dtr[31];
					magl_q       <= dtl[31] ? (32'd0 - dtl) : dtl;
					magr_q       <= dtr[31] ? (32'd0 - dtr) : dtr;
					ma_q         <= {64'd0, dtl[31] ? (32'd0 - dtl) : dtl};
					mb_q         <= lpt_q;
					mop_q        <= OP_L;
					limb_q       <= 2'd0;
					prev_left_q  <= cl_q;
					prev_right_q <= cr_q;
					prev_stamp_q <= stamp_q;
					state_q      <= S_MUL;
				end
				S_MUL: begin
					// Products of limbs are registered and added to the accumulator in the cycle after.
					prod_q <= prod_d;
					if (limb_q == 2'd0)
						macc_q <= 128'd0;
					else
						macc_q <= macc_q + macc_add;
					if (limb_q == 2'd3)
						state_q <= S_POST;
					limb_q <= limb_q + 2'd1;
				end
				S_POST: begin
					limb_q <= 2'd0;
					unique case (mop_q)
						OP_L: begin
							dl_q    <= whd;
							ma_q    <= {64'd0, magr_q};
							mb_q    <= rpt_q;
							mop_q   <= OP_R;
							state_q <= S_MUL;
						end
						OP_R: begin
							dr_q    <= whd;
							state_q <= S_SUM;
						end
						OP_T: begin
							tmag_q  <= tmag_d;
							tlow_q  <= tneg_q ? (64'd0 - tmag_d) : tmag_d;
							ma_q    <= {40'd0, dsm_q};
							mb_q    <= CORDIC_GAIN_Q32;
							mop_q   <= OP_X;
							state_q <= S_MUL;
						end
						OP_X: begin
							x_q     <= fold ? -x_init : x_init;
							y_q     <= 64'sd0;
							z_q     <= 34'(signed'(phi_f));
							step_q  <= '0;
							state_q <= S_CORD;
						end
						OP_V1: begin
							dvd_q   <= macc_q[DVD_W-1:0];
							rem_q   <= 33'd0;
							dcnt_q  <= '0;
							dop_q   <= 1'b0;
							state_q <= S_DIV;
						end
						OP_V2A: begin
							ma_q    <= macc_q[95:0];
							mb_q    <= PI_Q29;
							mop_q   <= OP_V2B;
							state_q <= S_MUL;
						end
						OP_V2B: begin
							dvd_q   <= macc_q[DVD_W-1:0];
							rem_q   <= 33'd0;
							dcnt_q  <= '0;
							dop_q   <= 1'b1;
							state_q <= S_DIV;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SUM: begin
					sum_q   <= 58'(dl_q) + 58'(dr_q);
					diff_q  <= 58'(dr_q) - 58'(dl_q);
					state_q <= S_ABS;
				end
				S_ABS: begin
					dsneg_q <= ds_full[57];
					dsm_q   <= ds_full[57] ? 56'(-ds_full) : ds_full[55:0];
					tneg_q  <= diff_q[57];
					ma_q    <= {38'd0, diff_q[57] ? -diff_q : diff_q};
					mb_q    <= gain_q;
					mop_q   <= OP_T;
					limb_q  <= 2'd0;
					state_q <= S_MUL;
				end
				S_CORD: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atz;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atz;
					end
					step_q <= step_q + SW'(1);
					if (step_q == SW'(CORDIC_STEPS - 1))
						state_q <= S_POST;
					if (step_q == SW'(CORDIC_STEPS - 1)) begin
						if (!z_q[33]) begin
							acc_x_q <= acc_x_q + POS_W'(x_q - ys);
							acc_y_q <= acc_y_q + POS_W'(y_q + xs);
						end else begin
							acc_x_q <= acc_x_q + POS_W'(x_q + ys);
							acc_y_q <= acc_y_q + POS_W'(y_q - xs);
						end
						acc_h_q <= acc_h_q + tlow_q[31:0];
						limb_q  <= 2'd0;
						if (dt_q == 32'd0) begin
							lin_q   <= 32'd0;
							ang_q   <= 32'd0;
							valid_q <= 1'b0;
							state_q <= S_FIN;
						end else begin
							ma_q    <= {40'd0, dsm_q};
							mb_q    <= MS_PER_S;
							mop_q   <= OP_V1;
							state_q <= S_MUL;
						end
					end
				end
				S_DIV: begin
					rem_q  <= qbit ? (rsh - {1'b0, dt_q}) : rsh;
					dvd_q  <= {dvd_q[DVD_W-2:0], qbit};
					dcnt_q <= dcnt_q + CW'(1);
					if (dcnt_q == CW'(DVD_W - 1)) begin
						limb_q <= 2'd0;
						if (!dop_q) begin
							lin_q   <= sat32({dvd_q[DVD_W-2:0], qbit} >> 8, dsneg_q);
							ma_q    <= {32'd0, tmag_q};
							mb_q    <= MS_PER_S;
							mop_q   <= OP_V2A;
							state_q <= S_MUL;
						end else begin
							ang_q   <= sat32({dvd_q[DVD_W-2:0], qbit} >> 44, tneg_q);
							valid_q <= 1'b1;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						ox_q     <= acc_x_q;
						oy_q     <= acc_y_q;
						oh_q     <= acc_h_q;
						olin_q   <= lin_q;
						oang_q   <= ang_q;
						ospd_q   <= valid_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.pos_x         = ox_q;
	assign out_ch.pos_y         = oy_q;
	assign out_ch.heading_angle = oh_q;
	assign out_ch.lin_speed     = olin_q;
	assign out_ch.ang_speed     = oang_q;
	assign out_ch.speed_valid   = ospd_q;

	// A transfer in starts the sequencer.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != S_IDLE)
		else $error("sequencer did not start after an input transfer");

	// The partial remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < {1'b0, dt_q})
		else $error("divider remainder out of range");

	// Division only runs on a nonzero time delta.
	a_div_dt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dt_q != 32'd0)
		else $error("division by a zero time delta");

	// Leaving the final state always loads a result.
	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && slot_free |=> ovalid_q)
		else $error("result not loaded into the output register");

	// Once primed, the block stays primed.
	a_primed: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped");

endmodule
`default_nettype wire
